FILE: src/tlfq_pkg.sv
package tlfq_pkg;

    typedef enum logic [1:0] {
        ACT_ENQ   = 2'd0,
        ACT_DEQ   = 2'd1,
        ACT_AGE   = 2'd2,
        ACT_CHECK = 2'd3
    } action_t;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic [2:0] CFG_AGING_WAIT = 3'd0;
    localparam logic [2:0] CFG_AGING_STEP = 3'd1;
    localparam logic [2:0] CFG_L3_QUANTUM = 3'd2;
    localparam logic [2:0] CFG_HIGH_FLOOR = 3'd3;
    localparam logic [2:0] CFG_MID_FLOOR  = 3'd4;
    localparam logic [2:0] CFG_PRIO_CAP   = 3'd5;

    // slot entry: task, priority, burst, wait start, arrival
    typedef struct packed {
        logic [7:0]  task_id;
        logic [7:0]  prio;
        logic [15:0] burst;
        logic [31:0] wait_start;
        logic [15:0] arrival;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);

endpackage

FILE: src/tlfq_ram.sv
module tlfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: src/three_level_feedback_ready_queue.sv
// Three-level ready queue with aging. Enqueue writes a free slot, if there is
// one, without a sweep. Dequeue, aging pass and preempt check each sweep the
// slot table once, one slot per cycle through the single-port-read slot
// memory. One item is worked on at a time; a result waits in the output
// register while the next transfer in is already taken.
// Slot occupancy bits are flip-flops cleared by reset; the slot memory itself
// needs no clearing pass.
module three_level_feedback_ready_queue
    import tlfq_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [15:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // action[1:0], thread_id[9:2], priority_req[17:10], burst_estimate[33:18],
    // now[65:34], run_time[97:66], zero fill [103:98]
    input  logic [103:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[1:0], picked_valid[2], picked_thread[10:3], picked_level[12:11],
    // preempt[13], zero fill [15:14]
    output logic [15:0]  m_tdata
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = AW + 1;

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_LAST, S_DONE, S_HOLD} state_t;

    state_t state_reg;
    logic [TABLE_DEPTH-1:0] used_reg;
    logic [15:0] aging_wait_reg, l3_quantum_reg, arrival_reg;
    logic [7:0]  aging_step_reg, high_floor_reg, mid_floor_reg, cap_reg;

    action_t     act_reg;
    logic [7:0]  tid_reg, prio_reg;
    logic [15:0] burst_reg;
    logic [31:0] now_reg, run_reg;

    logic [CW-1:0] cnt_reg;
    logic [AW-1:0] rd_idx_reg;
    logic          rd_ok_reg;

    logic          best_ok_reg [1:3];
    slot_t         best_reg [1:3];
    logic [AW-1:0] best_idx_reg [1:3];

    logic        out_full_reg;
    logic [15:0] out_reg;
    logic [15:0] res_reg;
    logic        pend_reg;
    logic [97:0] pend_data_reg;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    slot_t         wr_data, rd_data;
    logic [AW-1:0] rd_addr;

    tlfq_ram #(.WIDTH(SLOT_W), .DEPTH(TABLE_DEPTH)) u_slots (
        .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .rd_addr(rd_addr), .rd_data(rd_data)
    );

    function automatic logic [1:0] level_of(input logic [7:0] p, input logic [7:0] hf,
                                            input logic [7:0] mf);
        logic [1:0] l;
        if (p >= hf) l = 2'd1;
        else if (p >= mf) l = 2'd2;
        else l = 2'd3;
        return l;
    endfunction

    // free slot search (priority encoder over used bits)
    logic          free_ok;
    logic [AW-1:0] free_idx;
    always_comb
    begin
        free_ok  = 1'b0;
        free_idx = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_ok  = 1'b1;
                free_idx = AW'(i);
            end
        end
    end

    // scan datapath on the slot just read
    logic [1:0]  rd_lvl;
    logic        rd_better;
    slot_t       cb;
    logic [15:0] age_a, age_b;
    logic        aged;
    logic [8:0]  prio_sum;
    slot_t       aged_slot;

    always_comb
    begin
        rd_lvl = level_of(rd_data.prio, high_floor_reg, mid_floor_reg);
        cb     = best_reg[rd_lvl == 2'd0 ? 2'd3 : rd_lvl];
        age_a  = arrival_reg - rd_data.arrival;
        age_b  = arrival_reg - cb.arrival;
        if (rd_lvl == 2'd1 && rd_data.burst != cb.burst)
            rd_better = rd_data.burst < cb.burst;
        else if (rd_lvl == 2'd1 && rd_data.task_id != cb.task_id)
            rd_better = rd_data.task_id < cb.task_id;
        else if (rd_lvl == 2'd2 && rd_data.prio != cb.prio)
            rd_better = rd_data.prio > cb.prio;
        else if (rd_lvl == 2'd2 && rd_data.task_id != cb.task_id)
            rd_better = rd_data.task_id < cb.task_id;
        else
            rd_better = age_a > age_b;

        aged      = (now_reg - rd_data.wait_start) >= {16'd0, aging_wait_reg};
        prio_sum  = {1'b0, rd_data.prio} + {1'b0, aging_step_reg};
        aged_slot = rd_data;
        aged_slot.wait_start = now_reg;
        if (rd_data.prio < cap_reg)
            aged_slot.prio = (prio_sum > {1'b0, cap_reg}) ? cap_reg : prio_sum[7:0];
    end

    // final selection
    logic          sel_ok;
    logic [1:0]    sel_lvl;
    slot_t         sel;
    logic [AW-1:0] sel_idx;
    always_comb
    begin
        sel_ok = 1'b1; sel_lvl = 2'd0; sel = best_reg[3]; sel_idx = best_idx_reg[3];
        if (best_ok_reg[1])
        begin
            sel_lvl = 2'd1; sel = best_reg[1]; sel_idx = best_idx_reg[1];
        end
        else if (best_ok_reg[2])
        begin
            sel_lvl = 2'd2; sel = best_reg[2]; sel_idx = best_idx_reg[2];
        end
        else if (best_ok_reg[3])
            sel_lvl = 2'd3;
        else
            sel_ok = 1'b0;
    end

    logic [1:0] cur_lvl;
    logic       pre_v;
    always_comb
    begin
        cur_lvl = level_of(prio_reg, high_floor_reg, mid_floor_reg);
        pre_v   = 1'b0;
        if (cur_lvl == 2'd3 && run_reg >= {16'd0, l3_quantum_reg})
            pre_v = 1'b1;
        else if (sel_ok)
        begin
            if (sel_lvl < cur_lvl)
                pre_v = 1'b1;
            else if (sel_lvl == cur_lvl && cur_lvl == 2'd1)
                pre_v = (burst_reg > sel.burst) ||
                        (burst_reg == sel.burst && tid_reg > sel.task_id);
        end
    end

    logic [97:0] in_data;
    assign in_data = pend_reg ? pend_data_reg : s_tdata[97:0];
    logic start;
    assign start = (state_reg == S_IDLE) && (pend_reg || s_tvalid);

    assign s_tready = !pend_reg;
    assign m_tvalid = out_full_reg;
    assign m_tdata  = out_reg;
    assign rd_addr  = cnt_reg[AW-1:0];

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = rd_idx_reg;
        wr_data = aged_slot;
        if (start && action_t'(in_data[1:0]) == ACT_ENQ && free_ok)
        begin
            wr_en   = 1'b1;
            wr_addr = free_idx;
            wr_data = '{task_id: in_data[9:2], prio: in_data[17:10],
                        burst: in_data[33:18], wait_start: in_data[65:34],
                        arrival: arrival_reg};
        end
        else if ((state_reg == S_SCAN || state_reg == S_LAST) && act_reg == ACT_AGE &&
                 rd_ok_reg && aged)
            wr_en = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            used_reg       <= '0;
            aging_wait_reg <= 16'd1500;
            aging_step_reg <= 8'd10;
            l3_quantum_reg <= 16'd100;
            high_floor_reg <= 8'd100;
            mid_floor_reg  <= 8'd50;
            cap_reg        <= 8'd149;
            arrival_reg    <= '0;
            out_full_reg   <= 1'b0;
            pend_reg       <= 1'b0;
            rd_ok_reg      <= 1'b0;
            cnt_reg        <= '0;
            for (int l = 1; l <= 3; l++) best_ok_reg[l] <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_AGING_WAIT: aging_wait_reg <= cfg_data;
                    CFG_AGING_STEP: aging_step_reg <= cfg_data[7:0];
                    CFG_L3_QUANTUM: l3_quantum_reg <= cfg_data;
                    CFG_HIGH_FLOOR: high_floor_reg <= cfg_data[7:0];
                    CFG_MID_FLOOR:  mid_floor_reg  <= cfg_data[7:0];
                    CFG_PRIO_CAP:   cap_reg        <= cfg_data[7:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready)
                out_full_reg <= 1'b0;
            if (s_tvalid && s_tready && !(state_reg == S_IDLE && !pend_reg))
            begin
                pend_reg      <= 1'b1;
                pend_data_reg <= s_tdata[97:0];
            end
            else if (start && pend_reg)
                pend_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        act_reg   <= action_t'(in_data[1:0]);
                        tid_reg   <= in_data[9:2];
                        prio_reg  <= in_data[17:10];
                        burst_reg <= in_data[33:18];
                        now_reg   <= in_data[65:34];
                        run_reg   <= in_data[97:66];
                        cnt_reg   <= '0;
                        rd_ok_reg <= 1'b0;
                        for (int l = 1; l <= 3; l++) best_ok_reg[l] <= 1'b0;
                        if (action_t'(in_data[1:0]) == ACT_ENQ)
                        begin
                            if (free_ok)
                            begin
                                used_reg[free_idx] <= 1'b1;
                                arrival_reg <= arrival_reg + 16'd1;
                            end
                            res_reg   <= {14'd0, free_ok ? ST_OK : ST_FULL};
                            state_reg <= S_DONE;
                        end
                        else
                            state_reg <= S_SCAN;
                    end
                end
                S_SCAN, S_LAST:
                begin
                    if (rd_ok_reg && act_reg != ACT_AGE && rd_lvl != 2'd0 &&
                        (!best_ok_reg[rd_lvl] || rd_better))
                    begin
                        best_ok_reg[rd_lvl]  <= 1'b1;
                        best_reg[rd_lvl]     <= rd_data;
                        best_idx_reg[rd_lvl] <= rd_idx_reg;
                    end
                    rd_idx_reg <= cnt_reg[AW-1:0];
                    rd_ok_reg  <= (state_reg == S_SCAN) && used_reg[cnt_reg[AW-1:0]];
                    if (state_reg == S_SCAN)
                    begin
                        if (cnt_reg == CW'(TABLE_DEPTH - 1))
                            state_reg <= S_LAST;
                        else
                            cnt_reg <= cnt_reg + CW'(1);
                    end
                    else
                        state_reg <= S_HOLD;
                end
                S_HOLD:
                begin
                    res_reg <= '0;
                    if (act_reg == ACT_DEQ)
                    begin
                        if (sel_ok)
                        begin
                            used_reg[sel_idx] <= 1'b0;
                            res_reg <= {3'd0, sel_lvl, sel.task_id, 1'b1, ST_OK};
                        end
                        else
                            res_reg <= {14'd0, ST_EMPTY};
                    end
                    else if (act_reg == ACT_CHECK)
                        res_reg <= {2'd0, pre_v, 13'd0};
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (!out_full_reg || m_tready)
                    begin
                        out_reg      <= res_reg;
                        out_full_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: src/tlfq_checker.sv
module tlfq_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [15:0]  m_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped while stalled");

    a_pick_level: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[2] |-> m_tdata[12:11] != 2'd0 && m_tdata[1:0] == 2'd0)
        else $error("picked task without level");

    a_no_pick: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[2] |-> m_tdata[12:3] == 10'd0)
        else $error("picked fields set without a pick");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[1:0] != 2'd3 && m_tdata[15:14] == 2'd0)
        else $error("bad status");

endmodule

bind three_level_feedback_ready_queue tlfq_checker u_tlfq_checker (
    .clk(clk), .rst_n(rst_n),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
